### hdl/bsph_pkg.sv
package bsph_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W   = 5;
  localparam int LVL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int BC_W    = 6;
  localparam int DW_W    = 10;
  localparam int HOLD_W  = 16;
  localparam int DECAY_W = 16;
  localparam int HGT_W   = 7;
  localparam int BW_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int BANDS_IDX  = 32;

  // Smoothing weights in Q0.16, 0.7 and 0.3, and the rounding term.
  localparam logic [LVL_W-1:0] W_OLD      = 16'd45875;
  localparam logic [LVL_W-1:0] W_NEW      = 16'd19661;
  localparam logic [32:0]      ROUND_HALF = 33'd32768;

  localparam logic [BW_W-1:0] WIDTH_CAP = 5'd20;
  localparam logic [BW_W-1:0] SPACING   = 5'd2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd3;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic lay_en;
    logic mul_en;
    logic sum_en;
    logic peak_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

### hdl/bsph_div.sv
module bsph_div
  import bsph_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DW_W-1:0] dividend,
  input  logic [BC_W-1:0] divisor,
  output logic            last,
  output logic [DW_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DW_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW_W-1:0]  quo_r, quo_nxt;
  logic [BC_W-1:0]  rem_r, rem_nxt;
  logic [BC_W:0]    trial;
  logic [BC_W:0]    diff;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[DW_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(DW_W);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[BC_W-1:0];
        quo_nxt = {quo_r[DW_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BC_W-1:0];
        quo_nxt = {quo_r[DW_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign last     = (cnt_r == CNT_W'(1));
  assign quotient = quo_r;

endmodule

### hdl/bsph_datapath.sv
module bsph_datapath
  import bsph_pkg::*;
#(
  parameter int MAX_BAND_COUNT = 32,
  parameter int SCREEN_HEIGHT  = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SW    = (MAX_BAND_COUNT > 1) ? $clog2(MAX_BAND_COUNT) : 1;
  localparam int N_CAP = (MAX_BAND_COUNT > 63) ? 63 : MAX_BAND_COUNT;
  localparam int MAX_H = SCREEN_HEIGHT / 2 - 5;
  localparam int HW    = $clog2(MAX_H + 1);
  localparam int PW    = 23 + HW;

  // Configuration registers.
  logic [BC_W-1:0]    band_count_r;
  logic [DW_W-1:0]    panel_width_r;
  logic [HOLD_W-1:0]  hold_time_r;
  logic [DECAY_W-1:0] decay_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r    <= 6'd32;
      panel_width_r   <= 10'd320;
      hold_time_r     <= 16'd500;
      decay_factor_r  <= 16'd62259;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BAND_COUNT:   band_count_r   <= cfg_data[BC_W-1:0];
        REG_PANEL_WIDTH:  panel_width_r  <= cfg_data[DW_W-1:0];
        REG_HOLD_TIME:    hold_time_r    <= cfg_data[HOLD_W-1:0];
        REG_DECAY_FACTOR: decay_factor_r <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective band count, clamped to one up to the store depth or 63, whichever is smaller.
  logic [BC_W-1:0] n_eff;
  always_comb begin
    if (band_count_r == '0) begin
      n_eff = BC_W'(1);
    end else if (band_count_r > BC_W'(N_CAP)) begin
      n_eff = BC_W'(N_CAP);
    end else begin
      n_eff = band_count_r;
    end
  end

  // Layout: width per band from the divider, then spacing and centering.
  logic            div_last;
  logic [DW_W-1:0] div_q;

  bsph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (panel_width_r),
    .divisor  (n_eff),
    .last     (div_last),
    .quotient (div_q)
  );

  assign stat.div_last = div_last;

  logic [BW_W-1:0] w_cap, w_lay, wp2_lay;
  logic [DW_W:0]   total;
  logic [DW_W:0]   slack;
  logic [BW_W-1:0] w_r, wp2_r;
  logic [DW_W-1:0] start_r;

  always_comb begin
    w_cap   = (div_q > DW_W'(WIDTH_CAP)) ? WIDTH_CAP : div_q[BW_W-1:0];
    w_lay   = (w_cap > SPACING) ? (w_cap - SPACING) : w_cap;
    wp2_lay = w_lay + SPACING;
    total   = (DW_W+1)'(wp2_lay) * (DW_W+1)'(n_eff);
    slack   = {1'b0, panel_width_r} - total;
  end

  always_ff @(posedge clk) begin
    if (cmd.lay_en) begin
      w_r     <= w_lay;
      wp2_r   <= wp2_lay;
      start_r <= (total > {1'b0, panel_width_r}) ? '0 : {1'b0, slack[DW_W-1:1]};
    end
  end

  // Store entry selection: band index modulo the store depth, as a table.
  logic [SW-1:0] slot_tab [BANDS_IDX];
  for (genvar i = 0; i < BANDS_IDX; i++) begin : g_slot
    assign slot_tab[i] = SW'(i % MAX_BAND_COUNT);
  end

  logic [IDX_W-1:0]  in_idx;
  logic [LVL_W-1:0]  in_lvl;
  logic [TIME_W-1:0] in_now;
  logic [SW-1:0]     in_slot;

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_lvl  = in_tdata[IDX_W+LVL_W-1:IDX_W];
  assign in_now  = in_tdata[IDX_W+LVL_W+TIME_W-1:IDX_W+LVL_W];
  assign in_slot = slot_tab[in_idx];

  // Per-band stores. One valid bit per band covers all three stores; an
  // entry that was never written reads as zero.
  logic [LVL_W-1:0]  smooth_mem [MAX_BAND_COUNT];
  logic [LVL_W-1:0]  peak_mem   [MAX_BAND_COUNT];
  logic [TIME_W-1:0] time_mem   [MAX_BAND_COUNT];
  logic [MAX_BAND_COUNT-1:0] vld_r;

  logic [IDX_W-1:0]  idx_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [TIME_W-1:0] now_r;
  logic [SW-1:0]     slot_r;
  logic              rd_vld_r;
  logic [LVL_W-1:0]  sm_rd_r, pk_rd_r;
  logic [TIME_W-1:0] tm_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r    <= in_idx;
      lvl_r    <= in_lvl;
      now_r    <= in_now;
      slot_r   <= in_slot;
      rd_vld_r <= vld_r[in_slot];
      sm_rd_r  <= smooth_mem[in_slot];
      pk_rd_r  <= peak_mem[in_slot];
      tm_rd_r  <= time_mem[in_slot];
    end
  end

  logic [LVL_W-1:0]  sm_old, pk_old;
  logic [TIME_W-1:0] tm_old;
  assign sm_old = rd_vld_r ? sm_rd_r : '0;
  assign pk_old = rd_vld_r ? pk_rd_r : '0;
  assign tm_old = rd_vld_r ? tm_rd_r : '0;

  // Multiply step.
  logic [31:0]      p_old_r, p_new_r, p_dec_r;
  logic             hold_exp_r;
  logic [DW_W-1:0]  xoff_r;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_r - tm_old;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_old_r    <= 32'(sm_old) * 32'(W_OLD);
      p_new_r    <= 32'(lvl_r) * 32'(W_NEW);
      p_dec_r    <= 32'(pk_old) * 32'(decay_factor_r);
      hold_exp_r <= (elapsed > TIME_W'(hold_time_r));
      xoff_r     <= DW_W'(idx_r) * DW_W'(wp2_r);
    end
  end

  // Sum step: weighted sum with rounding, saturated to the Q0.16 range.
  logic [32:0]      acc;
  logic [LVL_W-1:0] s_r;
  assign acc = {1'b0, p_old_r} + {1'b0, p_new_r} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      s_r <= (acc[32] == 1'b1) ? '1 : acc[31:16];
    end
  end

  // Peak step: follow a rise, otherwise decay once the hold has expired.
  logic [LVL_W-1:0]  peak_new;
  logic [TIME_W-1:0] time_new;
  logic [LVL_W-1:0]  peak_r;
  logic [HGT_W-1:0]  bh_r;
  logic [PW-1:0]     bh_prod, ph_prod;

  always_comb begin
    time_new = tm_old;
    if (s_r > pk_old) begin
      peak_new = s_r;
      time_new = now_r;
    end else if (hold_exp_r) begin
      peak_new = p_dec_r[31:16];
    end else begin
      peak_new = pk_old;
    end
  end

  assign bh_prod = PW'(s_r) * PW'(MAX_H);

  always_ff @(posedge clk) begin
    if (cmd.peak_en) begin
      smooth_mem[slot_r] <= s_r;
      peak_mem[slot_r]   <= peak_new;
      time_mem[slot_r]   <= time_new;
      peak_r             <= peak_new;
      bh_r               <= bh_prod[22:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.peak_en) begin
      vld_r[slot_r] <= 1'b1;
    end
  end

  // Output step.
  logic [HGT_W-1:0]      ph;
  logic                  vis;
  logic [DW_W-1:0]       bar_x;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign ph_prod = PW'(peak_r) * PW'(MAX_H);
  assign ph      = ph_prod[22:16];
  assign vis     = (ph > bh_r) && (ph > HGT_W'(2));
  assign bar_x   = start_r + xoff_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= {2'b00, w_r, bar_x, vis, ph, bh_r, s_r};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

### hdl/bsph_ctrl.sv
module bsph_ctrl
  import bsph_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  output ctrl_cmd_t            cmd,
  input  dp_stat_t             stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LFIN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_PEAK = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       layout_ok_r, layout_ok_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       cfg_lay;

  // A write to either layout register makes the cached layout stale.
  assign cfg_lay = cfg_we && (cfg_index inside {REG_BAND_COUNT, REG_PANEL_WIDTH});

  always_comb begin
    state_nxt     = state_r;
    layout_ok_nxt = layout_ok_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (!layout_ok_r) begin
          if (!cfg_lay) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_DIV: begin
        if (cfg_lay) begin
          state_nxt = ST_IDLE;
        end else if (stat.div_last) begin
          state_nxt = ST_LFIN;
        end
      end
      ST_LFIN: begin
        if (!cfg_lay) begin
          cmd.lay_en    = 1'b1;
          layout_ok_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_PEAK;
      end
      ST_PEAK: begin
        cmd.peak_en = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_lay) begin
      layout_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      layout_ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      layout_ok_r <= layout_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && layout_ok_r;
  assign out_tvalid = out_valid_r;

endmodule

### hdl/band_smooth_peak_hold_core.sv
// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    band_index, level, now_ms
// out_     master     out_tvalid / out_tready  smoothed_level .. bar_width
// cfg_     slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each word passes from acceptance to the output register through one read,
// three arithmetic steps and the output step of the controller sequence; the
// next word is accepted once the controller returns to idle after that step.
// After reset, and after any write to band_count or the panel width, the bar
// layout is rebuilt by a bit-serial divider before the next word is taken:
// one quotient bit per cycle for the 10-bit panel width.
// A result waits in the output register while the next word is processed;
// the output step stalls only if that register is still full.
// Reset clears the control state and the per-band valid bits and sets the config registers to their defaults.
module band_smooth_peak_hold_core
  import bsph_pkg::*;
#(
  parameter int MAX_BAND_COUNT = 32,
  parameter int SCREEN_HEIGHT  = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [4:0] band_index, [20:5] level, [52:21] now_ms, [55:53] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] smoothed_level, [22:16] bar_px, [29:23] peak_px,
  // [30] peak_visible, [40:31] bar_x, [45:41] bar_width, [47:46] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bsph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cmd        (cmd),
    .stat       (stat)
  );

  bsph_datapath #(
    .MAX_BAND_COUNT (MAX_BAND_COUNT),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

`ifndef SYNTHESIS
  // Only one word is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // A layout register write must hold off input until the layout is rebuilt.
  a_layout_stale: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_BAND_COUNT || cfg_index == REG_PANEL_WIDTH)
    |=> !in_tready)
    else $error("input ready with a stale layout");

  // The visible flag agrees with the two heights it was derived from.
  a_peak_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30]
    |-> (out_tdata[29:23] > out_tdata[22:16]) && (out_tdata[29:23] > 7'd2))
    else $error("peak_visible set without a peak above the bar");
`endif

endmodule
